// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the decompressor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LZ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LZ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lz77td_pkg.sv
// ----------------------------------------------------------------------------
// lz77td_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package lz77td_pkg;

  localparam int BYTE_W         = 8;
  localparam int WINDOW_SIZE    = 4096;
  localparam int WIN_AW         = $clog2(WINDOW_SIZE);
  localparam int MIN_MATCH      = 3;
  localparam int COUNT_BITS_DEF = 24;
  localparam int OUT_COUNT_W    = 24;
  localparam int CAP_W          = 24;
  localparam int STATUS_W       = 3;
  localparam int LEN_W          = 5;
  localparam int NIB_W          = 4;
  localparam int TAG_LIT_BIT    = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = '1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DATA    = 3'd0,
    ST_DONE    = 3'd1,
    ST_TRUNC   = 3'd2,
    ST_BADDIST = 3'd3,
    ST_OVER    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_TAG = 2'd0,
    PH_LIT = 2'd1,
    PH_DLO = 2'd2,
    PH_DHI = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EM_LIT  = 2'd0,
    EM_COPY = 2'd1,
    EM_STAT = 2'd2
  } emit_kind_t;

  typedef struct packed {
    logic       accept;
    logic       load_len;
    logic       load_dlo;
    logic       start_copy;
    logic       emit;
    emit_kind_t kind;
    status_t    status;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic in_start;
    logic tag_lit;
    logic item_end;
    logic can_emit;
    logic cap_hit;
    logic dist_bad;
    logic copy_last;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/lz77td_if.sv
// ----------------------------------------------------------------------------
// lz77td interfaces
// Valid/ready channels for compressed input, decoded results and config.
// ----------------------------------------------------------------------------
`default_nettype none

interface lz77td_in_if import lz77td_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              stream_start;
  logic              stream_end;

  modport source (output valid, in_byte, stream_start, stream_end, input ready);
  modport sink   (input valid, in_byte, stream_start, stream_end, output ready);
endinterface

interface lz77td_out_if import lz77td_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [BYTE_W-1:0]      out_byte;
  logic [STATUS_W-1:0]    status;
  logic [OUT_COUNT_W-1:0] out_count;
  logic                   last;

  modport source (output valid, out_byte, status, out_count, last, input ready);
  modport sink   (input valid, out_byte, status, out_count, last, output ready);
endinterface

interface lz77td_cfg_if import lz77td_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: rtl/lz77td_ram.sv
// ----------------------------------------------------------------------------
// lz77td_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module lz77td_ram import lz77td_pkg::*; #(
  parameter int WIDTH = BYTE_W,
  parameter int DEPTH = WINDOW_SIZE
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/lz77td_dp.sv
// ----------------------------------------------------------------------------
// lz77td_dp
// Datapath: item register, byte counter, match copy pointers, history RAM,
// capacity register and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lz77td_dp import lz77td_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  lz77td_in_if.sink          stream,
  lz77td_out_if.source       result,
  lz77td_cfg_if.sink         cfg
);

  localparam int CMP_W = (COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W;

  logic [BYTE_W-1:0]      item_byte;
  logic                   item_end;
  logic [COUNT_BITS-1:0]  count;
  logic [COUNT_BITS-1:0]  count_inc;
  logic [LEN_W-1:0]       len;
  logic [LEN_W-1:0]       remain;
  logic [BYTE_W-1:0]      dlo;
  logic [WIN_AW-1:0]      match_dist;
  logic [WIN_AW-1:0]      rd_ptr;
  logic [WIN_AW-1:0]      rd_addr;
  logic [WIN_AW-1:0]      wr_addr;
  logic [CAP_W-1:0]       capacity;
  logic                   rd_en;
  logic                   wr_en;
  logic [BYTE_W-1:0]      wr_data;
  logic [BYTE_W-1:0]      ram_q;
  logic                   fwd;
  logic [BYTE_W-1:0]      fwd_byte;
  logic [BYTE_W-1:0]      copy_byte;
  logic                   can_emit;
  logic                   cap_hit;
  logic                   dist_bad;

  logic                   ov;
  logic [BYTE_W-1:0]      ob;
  status_t                ost;
  logic [OUT_COUNT_W-1:0] ocnt;
  logic                   olast;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg.valid) begin
      capacity <= cfg.data;
    end
  end

  assign count_inc  = count + 1'b1;
  assign match_dist = {item_byte[NIB_W-1:0], dlo};
  assign dist_bad   = (match_dist == '0) || (COUNT_BITS'(match_dist) > count);
  // The limit is the smaller of capacity and the largest count value.
  assign cap_hit    = (CMP_W'(count) >= CMP_W'(capacity)) || (count == '1);
  assign can_emit   = !ov || result.ready;

  assign wr_en     = cmd.emit && (cmd.kind != EM_STAT);
  assign wr_addr   = count[WIN_AW-1:0];
  assign copy_byte = fwd ? fwd_byte : ram_q;
  assign wr_data   = (cmd.kind == EM_LIT) ? item_byte : copy_byte;
  assign rd_en     = cmd.start_copy || (cmd.emit && (cmd.kind == EM_COPY));
  assign rd_addr   = cmd.start_copy ? (count[WIN_AW-1:0] - match_dist) : (rd_ptr + 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_byte <= stream.in_byte;
      item_end  <= stream.stream_end;
    end
    if (cmd.load_len) begin
      len <= LEN_W'(item_byte[NIB_W-1:0]) + LEN_W'(MIN_MATCH);
    end
    if (cmd.load_dlo) begin
      dlo <= item_byte;
    end
    if (cmd.start_copy) begin
      rd_ptr <= rd_addr;
      remain <= len;
    end else if (cmd.emit && (cmd.kind == EM_COPY)) begin
      rd_ptr <= rd_addr;
      remain <= remain - 1'b1;
    end
    // Forward a byte written in the same cycle it is read (distance one).
    if (rd_en) begin
      fwd      <= wr_en && (wr_addr == rd_addr);
      fwd_byte <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept && stream.stream_start) begin
      count <= '0;
    end else if (wr_en) begin
      count <= count_inc;
    end
  end

  lz77td_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WINDOW_SIZE)
  ) u_hist (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (cmd.emit) begin
      ov <= 1'b1;
    end else if (result.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      olast <= cmd.last;
      if (cmd.kind == EM_STAT) begin
        ob   <= '0;
        ost  <= cmd.status;
        ocnt <= OUT_COUNT_W'(count);
      end else begin
        ob   <= wr_data;
        ost  <= ST_DATA;
        ocnt <= OUT_COUNT_W'(count_inc);
      end
    end
  end

  assign result.valid     = ov;
  assign result.out_byte  = ob;
  assign result.status    = ost;
  assign result.out_count = ocnt;
  assign result.last      = olast;

  assign sts.in_start  = stream.stream_start;
  assign sts.tag_lit   = item_byte[TAG_LIT_BIT];
  assign sts.item_end  = item_end;
  assign sts.can_emit  = can_emit;
  assign sts.cap_hit   = cap_hit;
  assign sts.dist_bad  = dist_bad;
  assign sts.copy_last = (remain == LEN_W'(1));

  `LZ_ASSERT_IMPL(a_copy_dist_ok, clk, rst, cmd.start_copy, !dist_bad,
                  "match copy started with a bad distance")
  `LZ_ASSERT_IMPL(a_data_in_cap, clk, rst, wr_en, !cap_hit,
                  "data byte written past the capacity limit")

endmodule

`default_nettype wire

// File: rtl/lz77td_ctrl.sv
// ----------------------------------------------------------------------------
// lz77td_ctrl
// Controller: token parser, error/close state and match copy sequencing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lz77td_ctrl import lz77td_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_COPY   = 5'b00100,
    S_FIN    = 5'b01000,
    S_SPARE  = 5'b10000
  } state_t;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   err, err_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_TAG;
      err   <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      err   <= err_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    phase_next = phase;
    err_next   = err;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECODE;
          if (sts.in_start) begin
            phase_next = PH_TAG;
            err_next   = 1'b0;
          end
        end
      end
      S_DECODE: begin
        if (err) begin
          // drop bytes of a closed stream
          state_next = S_IDLE;
        end else if (sts.can_emit) begin
          state_next = S_IDLE;
          case (phase)
            PH_TAG: begin
              cmd.load_len = !sts.tag_lit;
              phase_next   = sts.tag_lit ? PH_LIT : PH_DLO;
              if (sts.item_end) begin
                cmd.emit   = 1'b1;
                cmd.kind   = EM_STAT;
                cmd.status = ST_TRUNC;
                cmd.last   = 1'b1;
                err_next   = 1'b1;
                phase_next = PH_TAG;
              end
            end
            PH_LIT: begin
              phase_next = PH_TAG;
              cmd.emit   = 1'b1;
              if (sts.cap_hit) begin
                cmd.kind   = EM_STAT;
                cmd.status = ST_OVER;
                cmd.last   = 1'b1;
                err_next   = 1'b1;
              end else begin
                cmd.kind   = EM_LIT;
                cmd.last   = !sts.item_end;
                state_next = sts.item_end ? S_FIN : S_IDLE;
              end
            end
            PH_DLO: begin
              cmd.load_dlo = 1'b1;
              phase_next   = PH_DHI;
              if (sts.item_end) begin
                cmd.emit   = 1'b1;
                cmd.kind   = EM_STAT;
                cmd.status = ST_TRUNC;
                cmd.last   = 1'b1;
                err_next   = 1'b1;
                phase_next = PH_TAG;
              end
            end
            PH_DHI: begin
              phase_next = PH_TAG;
              if (sts.dist_bad) begin
                cmd.emit   = 1'b1;
                cmd.kind   = EM_STAT;
                cmd.status = ST_BADDIST;
                cmd.last   = 1'b1;
                err_next   = 1'b1;
              end else begin
                cmd.start_copy = 1'b1;
                state_next     = S_COPY;
              end
            end
            default: begin
              phase_next = PH_TAG;
            end
          endcase
        end
      end
      S_COPY: begin
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          if (sts.cap_hit) begin
            cmd.kind   = EM_STAT;
            cmd.status = ST_OVER;
            cmd.last   = 1'b1;
            err_next   = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.kind = EM_COPY;
            cmd.last = sts.copy_last && !sts.item_end;
            if (sts.copy_last) begin
              state_next = sts.item_end ? S_FIN : S_IDLE;
            end
          end
        end
      end
      S_FIN: begin
        if (sts.can_emit) begin
          cmd.emit   = 1'b1;
          cmd.kind   = EM_STAT;
          cmd.status = ST_DONE;
          cmd.last   = 1'b1;
          err_next   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `LZ_ASSERT_IMPL(a_emit_slot, clk, rst, cmd.emit, sts.can_emit,
                  "result issued while the output register is full")
  `LZ_ASSERT_NEXT(a_close_latch, clk, rst, cmd.emit && (cmd.kind == EM_STAT), err,
                  "stream not closed after a status result")
  `LZ_ASSERT_IMPL(a_copy_phase, clk, rst, state == S_COPY, phase == PH_TAG,
                  "parser not back at tag during a match copy")

endmodule

`default_nettype wire

// File: rtl/lz77_tag_stream_decompressor_core.sv
// ----------------------------------------------------------------------------
// lz77_tag_stream_decompressor_core: LZ77 tag-stream decoder, 4 KiB history.
// Each input byte is accepted, then decoded once the output register has room;
// a literal result is registered from its decode step. A match distance byte
// copies L = 3..18 bytes, one per history RAM read, stalling on a full output.
// Reset (rst, synchronous): count, parser, close flag clear; capacity all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module lz77_tag_stream_decompressor_core import lz77td_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  lz77td_in_if.sink    stream,
  lz77td_out_if.source result,
  lz77td_cfg_if.sink   cfg
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign stream.ready = in_ready;

  lz77td_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lz77td_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .stream (stream),
    .result (result),
    .cfg    (cfg)
  );

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: LZ77 tag-stream decompressor core
// Drives compressed streams into the core and decodes them alongside in a
// behavioral decoder that keeps its own 4 KiB history, count, parser and
// capacity. Every decoded item is compared field by field in order. Covers
// literals, shortest and longest matches, bad distances, truncated tokens,
// capacity overflow, restarts, back-pressure and random streams.
// ----------------------------------------------------------------------------
module tb;
  import lz77td_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 280;
  localparam int CALM_ITEMS   = 60;

  typedef struct packed {
    logic [BYTE_W-1:0]      out_byte;
    status_t                status;
    logic [OUT_COUNT_W-1:0] out_count;
    logic                   last;
  } decoded_t;

  logic clk = 1'b0;
  logic rst;

  lz77td_in_if  stream_if ();
  lz77td_out_if result_if ();
  lz77td_cfg_if cfg_if ();

  lz77_tag_stream_decompressor_core DUT (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Decoder state
  logic [7:0]             hist [0:WINDOW_SIZE-1];
  logic [OUT_COUNT_W-1:0] count;
  phase_t                 phase;
  logic [LEN_W-1:0]       match_len;
  logic [7:0]             dist_lo;
  bit                     closed;
  logic [CAP_W-1:0]       capacity;

  decoded_t   decoded_q [$];
  decoded_t   step_q [$];
  logic [7:0] comp_q [$];

  int mismatch_count = 0;
  int live_items     = 0;
  int quiet_cycles   = 0;
  bit calm           = 1'b0;
  bit hold_req       = 1'b0;

  function automatic void decoder_reset();
    for (int i = 0; i < WINDOW_SIZE; i++) hist[i] = 8'h00;
    count     = '0;
    phase     = PH_TAG;
    match_len = '0;
    dist_lo   = '0;
    closed    = 1'b0;
    capacity  = CAP_RESET;
  endfunction

  function automatic void add_result(input logic [7:0] data, input status_t st);
    decoded_t r;
    r.out_byte  = data;
    r.status    = st;
    r.out_count = count;
    r.last      = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic void add_byte(input logic [7:0] data);
    hist[count[WIN_AW-1:0]] = data;
    count = count + 1'b1;
    add_result(data, ST_DATA);
  endfunction

  function automatic void close_with(input status_t st);
    closed = 1'b1;
    phase  = PH_TAG;
    add_result(8'h00, st);
  endfunction

  function automatic void decode_byte(input logic [7:0] data, input logic start,
                                      input logic fin);
    logic [11:0]            back_dist;
    logic [OUT_COUNT_W-1:0] back;
    step_q.delete();
    if (start) begin
      count     = '0;
      phase     = PH_TAG;
      match_len = '0;
      dist_lo   = '0;
      closed    = 1'b0;
    end
    if (!closed) begin
      case (phase)
        PH_TAG: begin
          if (data[TAG_LIT_BIT]) begin
            phase = PH_LIT;
          end else begin
            match_len = LEN_W'(data[3:0]) + LEN_W'(MIN_MATCH);
            phase = PH_DLO;
          end
        end
        PH_LIT: begin
          phase = PH_TAG;
          if (count >= capacity) close_with(ST_OVER);
          else add_byte(data);
        end
        PH_DLO: begin
          dist_lo = data;
          phase = PH_DHI;
        end
        default: begin
          back_dist = {data[3:0], dist_lo};
          phase = PH_TAG;
          if (back_dist == 0 || OUT_COUNT_W'(back_dist) > count) begin
            close_with(ST_BADDIST);
          end else begin
            for (int i = 0; i < match_len && !closed; i++) begin
              if (count >= capacity) begin
                close_with(ST_OVER);
              end else begin
                back = count - OUT_COUNT_W'(back_dist);
                add_byte(hist[back[WIN_AW-1:0]]);
              end
            end
          end
        end
      endcase
      if (fin && !closed) begin
        if (phase != PH_TAG) begin
          close_with(ST_TRUNC);
        end else begin
          add_result(8'h00, ST_DONE);
          closed = 1'b1;
        end
      end
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) decoded_q.push_back(step_q[i]);
  endfunction

  // Stimulus helpers
  task automatic send_byte(input logic [7:0] data, input logic start, input logic fin);
    if (!calm && $urandom_range(0, 4) == 0) begin
      stream_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    stream_if.valid        <= 1'b1;
    stream_if.in_byte      <= data;
    stream_if.stream_start <= start;
    stream_if.stream_end   <= fin;
    @(posedge clk);
    while (!stream_if.ready) @(posedge clk);
    if (start || !closed) live_items++;
    decode_byte(data, start, fin);
  endtask

  task automatic send_stream(input bit with_end);
    foreach (comp_q[i])
      send_byte(comp_q[i], i == 0, with_end && i == comp_q.size() - 1);
  endtask

  task automatic drain_results();
    stream_if.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    // tags and distance-low bytes make no item, so let the core settle
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    capacity = value;
  endtask

  function automatic logic [CAP_W-1:0] pick_capacity();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CAP_W'($urandom_range(1, 40));
      2:       return CAP_W'($urandom_range(41, 300));
      3:       return CAP_W'($urandom);
      default: return CAP_RESET;
    endcase
  endfunction

  // Fill comp_q; short mode adds rare bad distances; long favors full-length matches
  task automatic build_stream(input int tokens, input bit long_mode);
    int         made;
    int         d;
    int         reach;
    logic [3:0] len;
    comp_q.delete();
    made = 0;
    for (int t = 0; t < tokens; t++) begin
      if (made < (long_mode ? 8 : 1) || (!long_mode && $urandom_range(0, 2) == 0)) begin
        comp_q.push_back({1'b1, 7'($urandom)});
        comp_q.push_back(8'($urandom));
        made++;
      end else begin
        len   = long_mode ? 4'hF : 4'($urandom);
        reach = made > 4095 ? 4095 : made;
        if (!long_mode && $urandom_range(0, 24) == 0)
          d = (made >= 4095 || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(made + 1, 4095);
        else if ($urandom_range(0, 7) == 0)
          d = reach;
        else
          d = $urandom_range(1, reach);
        comp_q.push_back({1'b0, 3'($urandom), len});
        comp_q.push_back(d[7:0]);
        comp_q.push_back({4'($urandom), d[11:8]});
        made += len + MIN_MATCH;
      end
    end
  endtask

  // Tests
  task automatic test_basic_tokens();
    // literals 00 and FF, shortest match at distance 1, longest at distance 2
    comp_q = '{8'h80, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h7F, 8'h02, 8'hF0};
    send_stream(1'b1);
    // stream is closed after done: drop this byte
    send_byte(8'h80, 1'b0, 1'b1);
    drain_results();
  endtask

  task automatic test_bad_distance();
    comp_q = '{8'h00, 8'h00, 8'h00};
    send_stream(1'b1);
    comp_q = '{8'h80, 8'h22, 8'h05, 8'h02, 8'h00};
    send_stream(1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    drain_results();
  endtask

  task automatic test_truncation();
    send_byte(8'h81, 1'b1, 1'b1);
    comp_q = '{8'h03, 8'h01};
    send_stream(1'b1);
    drain_results();
  endtask

  task automatic test_restart_mid_token();
    comp_q = '{8'h80, 8'h41, 8'h05, 8'h01};
    send_stream(1'b0);
    comp_q = '{8'h80, 8'h55};
    send_stream(1'b1);
    drain_results();
  endtask

  task automatic test_capacity_limits();
    write_capacity('0);
    comp_q = '{8'h80, 8'hAA};
    send_stream(1'b1);
    write_capacity(CAP_W'(5));
    comp_q = '{8'h80, 8'h01, 8'h80, 8'h02, 8'h0F, 8'h01, 8'h00};
    send_stream(1'b1);
    write_capacity(CAP_W'(2));
    comp_q = '{8'h80, 8'h01, 8'h80, 8'h02, 8'h80, 8'h03};
    send_stream(1'b1);
    drain_results();
  endtask

  task automatic test_backpressure();
    write_capacity(CAP_RESET);
    hold_req = 1'b1;
    build_stream(24, 1'b1);
    send_stream(1'b1);
    drain_results();
  endtask

  task automatic test_random_streams();
    int goal;
    goal = live_items + RANDOM_ITEMS;
    while (live_items < goal) begin
      if (live_items >= goal - CALM_ITEMS) calm = 1'b1;
      case ($urandom_range(0, 19))
        0: write_capacity(pick_capacity());
        1, 2, 3, 4: begin
          repeat ($urandom_range(1, 6))
            send_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
        end
        default: begin
          build_stream($urandom_range(1, 12), 1'b0);
          if ($urandom_range(0, 9) == 0) void'(comp_q.pop_back());
          send_stream($urandom_range(0, 9) != 0);
        end
      endcase
    end
  endtask

  // Result receiver: random stalls, one long hold-off on request
  initial begin
    result_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        result_if.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    decoded_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: item expected none actual status %0h count %0h byte %0h",
                 $time, result_if.status, result_if.out_count, result_if.out_byte);
        mismatch_count++;
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", 32'(want.out_byte), 32'(result_if.out_byte));
        check_field("status", 32'(want.status), 32'(result_if.status));
        check_field("out_count", 32'(want.out_count), 32'(result_if.out_count));
        check_field("last", 32'(want.last), 32'(result_if.last));
      end
    end
  end

  // Watchdog: end the run when no channel moves an item for too long
  always @(posedge clk) begin
    if (rst || (stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst                    <= 1'b1;
    stream_if.valid        <= 1'b0;
    stream_if.in_byte      <= '0;
    stream_if.stream_start <= 1'b0;
    stream_if.stream_end   <= 1'b0;
    cfg_if.valid           <= 1'b0;
    cfg_if.data            <= '0;
    decoder_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_tokens();
    test_bad_distance();
    test_truncation();
    test_restart_mid_token();
    test_capacity_limits();
    test_backpressure();
    test_random_streams();

    drain_results();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lz77td_pkg.sv
rtl/lz77td_if.sv
rtl/lz77td_ram.sv
rtl/lz77td_dp.sv
rtl/lz77td_ctrl.sv
rtl/lz77_tag_stream_decompressor_core.sv
verif/tb.sv
